// ===== design/pixel_temporal_mean_variance_macros.svh =====
// Assertion macros used by the checker file of the pixel statistics block.
`ifndef PIXEL_TEMPORAL_MEAN_VARIANCE_MACROS_SVH
`define PIXEL_TEMPORAL_MEAN_VARIANCE_MACROS_SVH

// Checked at every clock edge outside reset.
`define PTMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PTMV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/ptmv_pkg.sv =====
// Shared types and constants of the pixel statistics block.
package ptmv_pkg;

    localparam int SUM_W    = 32;
    localparam int SQ_W     = 48;
    localparam int N_W      = 17;
    localparam int N2_W     = 33;
    localparam int NUM_W    = 65;
    localparam int DVD_W    = 73;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 38;
    localparam int IDX_W    = 16;
    localparam int CFG_W    = 17;
    localparam int HALF_W   = 24;
    localparam int CNT_W    = 7;
    localparam int DIV_LAST = DVD_W - 1;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul_lo;
        logic mul_hi;
        logic sub_load;
        logic div_step;
        logic var_load;
        logic out_load;
    } ptmv_cmd_t;

    typedef struct packed {
        logic fin;
    } ptmv_stat_t;

endpackage

// ===== design/ptmv_ctrl.sv =====
// Sequencer of the pixel statistics block.
module ptmv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ptmv_pkg::ptmv_stat_t stat,
    output ptmv_pkg::ptmv_cmd_t  cmd
);
    import ptmv_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_UPD   = 9'b000000010,
        ST_MUL1  = 9'b000000100,
        ST_MUL2  = 9'b000001000,
        ST_SUB   = 9'b000010000,
        ST_DIVM  = 9'b000100000,
        ST_VLOAD = 9'b001000000,
        ST_DIVV  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = stat.fin ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.sub_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVM;
            end
            ST_DIVM: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_LAST)) begin
                    state_next = ST_VLOAD;
                end
            end
            ST_VLOAD: begin
                cmd.var_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVV;
            end
            ST_DIVV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_LAST)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/ptmv_dp.sv =====
// Datapath of the pixel statistics block: stores, counters, multipliers and divider.
module ptmv_dp #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_FRAMES = 65536,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [15:0]                    s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_we,
    input  logic [ptmv_pkg::CFG_W-1:0]     cfg_wdata,
    input  ptmv_pkg::ptmv_cmd_t            cmd,
    output ptmv_pkg::ptmv_stat_t           stat,
    output logic [79:0]                    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import ptmv_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SIZE_W = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int FR_W   = $clog2(MAX_FRAMES + 1);

    logic [SUM_W+SQ_W-1:0] mem [MAX_PIXELS];

    logic [CFG_W-1:0]      cfg_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [FR_W-1:0]       fs_reg;
    logic                  ovf_reg;

    logic [SIZE_W-1:0]     size_c, pos_ext, p_ext;
    logic [ADDR_W-1:0]     p_c;
    logic                  eof_c, skip_c, first_c;
    logic [N_W-1:0]        n_c;

    logic [ADDR_W-1:0]     p_reg;
    logic [PIXEL_BITS-1:0] v_reg;
    logic [2*PIXEL_BITS-1:0] vsq_reg;
    logic                  fin_reg, eof_reg, skip_reg, first_reg, oflag_reg;
    logic [N_W-1:0]        n_reg;
    logic [SUM_W+SQ_W-1:0] rd_reg;
    logic [SUM_W-1:0]      s_reg, s_new;
    logic [SQ_W-1:0]       q_reg, q_new;
    logic [2*SUM_W-1:0]    ss_reg;
    logic [HALF_W+N_W-1:0] plo_reg, phi_reg;
    logic [N2_W-1:0]       n2_reg;
    logic [NUM_W-1:0]      a_c, num_reg;

    logic [DVD_W-1:0]      dvd_reg;
    logic [N2_W-1:0]       rem_reg, dsr_reg;
    logic [VAR_W-1:0]      quo_reg;
    logic [N2_W:0]         rem_ext;
    logic                  ge_c;
    logic [MEAN_W-1:0]     mean_reg;
    logic [31:0]           p32;

    always_comb begin
        if (cfg_reg == '0) begin
            size_c = SIZE_W'(1);
        end else if (SIZE_W'(cfg_reg) > SIZE_W'(MAX_PIXELS)) begin
            size_c = SIZE_W'(MAX_PIXELS);
        end else begin
            size_c = SIZE_W'(cfg_reg);
        end
        pos_ext = SIZE_W'(pos_reg);
        p_ext   = (pos_ext >= size_c) ? size_c - 1'b1 : pos_ext;
        p_c     = p_ext[ADDR_W-1:0];
        eof_c   = (p_ext + 1'b1) >= size_c;
        skip_c  = (fs_reg >= FR_W'(MAX_FRAMES));
        first_c = (fs_reg == '0);
        n_c     = skip_c ? N_W'(MAX_FRAMES) : N_W'(fs_reg) + 1'b1;
    end

    assign stat.fin = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(65536);
            pos_reg <= '0;
            fs_reg  <= '0;
            ovf_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                pos_reg <= eof_c ? '0 : p_c + 1'b1;
                if (eof_c && s_tuser) begin
                    fs_reg  <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    if (skip_c) begin
                        ovf_reg <= 1'b1;
                    end
                    if (eof_c && !skip_c) begin
                        fs_reg <= fs_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            p_reg     <= p_c;
            v_reg     <= s_tdata[PIXEL_BITS-1:0];
            vsq_reg   <= s_tdata[PIXEL_BITS-1:0] * s_tdata[PIXEL_BITS-1:0];
            fin_reg   <= s_tuser;
            eof_reg   <= eof_c;
            skip_reg  <= skip_c;
            first_reg <= first_c;
            oflag_reg <= ovf_reg | skip_c;
            n_reg     <= n_c;
            rd_reg    <= mem[p_c];
        end
    end

    always_comb begin
        if (skip_reg) begin
            s_new = rd_reg[SUM_W-1:0];
            q_new = rd_reg[SUM_W+SQ_W-1:SUM_W];
        end else if (first_reg) begin
            s_new = SUM_W'(v_reg);
            q_new = SQ_W'(vsq_reg);
        end else begin
            s_new = rd_reg[SUM_W-1:0] + SUM_W'(v_reg);
            q_new = rd_reg[SUM_W+SQ_W-1:SUM_W] + SQ_W'(vsq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && !skip_reg) begin
            mem[p_reg] <= {q_new, s_new};
        end
    end

    assign a_c = (NUM_W'(phi_reg) << HALF_W) + NUM_W'(plo_reg);

    assign rem_ext = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge_c    = rem_ext >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            s_reg <= s_new;
            q_reg <= q_new;
        end
        if (cmd.mul_lo) begin
            plo_reg <= n_reg * q_reg[HALF_W-1:0];
            ss_reg  <= s_reg * s_reg;
        end
        if (cmd.mul_hi) begin
            phi_reg <= n_reg * q_reg[SQ_W-1:HALF_W];
            n2_reg  <= N2_W'(n_reg * n_reg);
        end
        if (cmd.sub_load) begin
            num_reg <= (a_c > NUM_W'(ss_reg)) ? a_c - NUM_W'(ss_reg) : '0;
            dvd_reg <= DVD_W'({s_reg, 8'd0});
            dsr_reg <= N2_W'(n_reg);
            rem_reg <= '0;
        end else if (cmd.var_load) begin
            mean_reg <= quo_reg[MEAN_W-1:0];
            dvd_reg  <= {num_reg, 8'd0};
            dsr_reg  <= n2_reg;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge_c ? N2_W'(rem_ext - {1'b0, dsr_reg}) : rem_ext[N2_W-1:0];
            quo_reg <= {quo_reg[VAR_W-2:0], ge_c};
        end
    end

    assign p32 = 32'(p_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata <= {2'b00, quo_reg, mean_reg, p32[IDX_W-1:0]};
            m_tlast <= eof_reg;
            m_tuser <= oflag_reg;
        end
    end

endmodule

// ===== design/pixel_temporal_mean_variance.sv =====
// Top level of the per-pixel temporal mean and variance block.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  tdata: pixel_value; tuser: final_frame
//  m_       out  m_tvalid/m_tready  tdata: pixel_index, mean_q8, variance_q8;
//                                   tuser: frames_overflow; tlast: last_pixel
//  cfg_     in   cfg_we             cfg_wdata: pixels_per_frame
//
// An item of a non-final frame is accepted with the store read, and then goes through
// the read-modify-write of the sum and square-sum store.
// An item of the final frame goes on through the shared bit-serial divider, which
// forms the mean and then the variance one quotient bit a cycle.
// The result sits in an output register, so a stalled output holds only the next
// final-frame item. Reset is synchronous; the stores need no clearing.
module pixel_temporal_mean_variance #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_FRAMES = 65536,
    parameter int PIXEL_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] pixel_value
    input  logic                       s_tuser,   // [0] final_frame
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata,   // [15:0] pixel_index, [39:16] mean_q8,
                                                  // [77:40] variance_q8, zero above
    output logic                       m_tuser,   // [0] frames_overflow
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [ptmv_pkg::CFG_W-1:0] cfg_wdata
);
    import ptmv_pkg::*;

    ptmv_cmd_t  cmd;
    ptmv_stat_t stat;

    ptmv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptmv_dp #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_FRAMES (MAX_FRAMES),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/ptmv_checker.sv =====
// Port-level checker of the pixel statistics block and its binding.
`include "pixel_temporal_mean_variance_macros.svh"

module ptmv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    `PTMV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held item changed")
    `PTMV_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")
    `PTMV_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
    `PTMV_ASSERT(a_single_result, m_tvalid && m_tready |=> !m_tvalid || s_tready, "result repeated")
endmodule

bind pixel_temporal_mean_variance ptmv_checker u_ptmv_checker (.*);

// ===== dv/pixel_temporal_mean_variance_tb.sv =====
// Testbench for the per-pixel temporal mean and variance block, with a self-checking predictor.
`timescale 1ns / 100ps
module pixel_temporal_mean_variance_tb;
    import ptmv_pkg::*;

    localparam int MAXPIX = 65536;
    localparam int MAXFRM = 65536;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] value;
        logic        fin;
    } pixel_item_t;

    typedef struct packed {
        logic [15:0] index;
        logic [23:0] mean;
        logic [37:0] variance;
        logic        overflow;
        logic        last;
    } pixel_stat_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [15:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [79:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    pixel_temporal_mean_variance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Predictor state.
    logic [31:0] acc_sum [int];
    logic [47:0] acc_sq [int];
    int unsigned cur_pos;
    int unsigned frames_done;
    bit          ovf_flag;
    logic [16:0] frame_cfg;

    pixel_item_t pending_pixels[$];
    pixel_stat_t expected_stats[$];
    int errors;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    bit recv_hold_req;
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned eff_size();
        int unsigned n;
        n = 32'(frame_cfg);
        if (n == 0) n = 1;
        if (n > MAXPIX) n = MAXPIX;
        return n;
    endfunction

    task automatic predict_pixel(input pixel_item_t it);
        int unsigned sz;
        int unsigned p;
        bit eof;
        logic [63:0] n, s, q, a, b, num, n2, quo, rem;
        pixel_stat_t r;
        sz = eff_size();
        if (cur_pos >= sz) cur_pos = sz - 1;
        p = cur_pos;
        eof = (p + 1 >= sz);
        if (frames_done == 0) begin
            acc_sum[p] = 32'(it.value);
            acc_sq[p] = 48'(it.value * it.value);
        end else if (frames_done < MAXFRM) begin
            acc_sum[p] = acc_sum[p] + 32'(it.value);
            acc_sq[p] = acc_sq[p] + 48'(64'(it.value) * it.value);
        end else begin
            ovf_flag = 1'b1;
        end
        n = (frames_done < MAXFRM) ? 64'(frames_done) + 64'd1 : 64'(MAXFRM);
        if (it.fin) begin
            s = 64'(acc_sum[p]);
            q = 64'(acc_sq[p]);
            a = n * q;
            b = s * s;
            r.index = p[15:0];
            r.mean = 24'((s << 8) / n);
            if (a <= b) begin
                r.variance = '0;
            end else begin
                num = a - b;
                n2 = n * n;
                quo = num / n2;
                rem = num % n2;
                r.variance = 38'((quo << 8) + ((rem << 8) / n2));
            end
            r.overflow = ovf_flag;
            r.last = eof;
            expected_stats.push_back(r);
        end
        if (eof) begin
            cur_pos = 0;
            if (it.fin) begin
                frames_done = 0;
                ovf_flag = 1'b0;
            end else if (frames_done < MAXFRM) begin
                frames_done++;
            end
        end else begin
            cur_pos = p + 1;
        end
    endtask

    // Driver: prediction happens at acceptance.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_pixel(pending_pixels.pop_front());
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready) begin
                // hold the offered item
            end else if (pending_pixels.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pixels[0].value;
                s_tuser <= pending_pixels[0].fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The acceptance clears the front; the driver offers the new front next.
    // Since the queue's front changes at acceptance, an offered item is popped only once.

    always @(negedge aclk) begin
        if (recv_hold_req) begin
            recv_hold <= 400;
            recv_hold_req <= 1'b0;
            m_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        pixel_stat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                $error("unexpected result, pixel_index %0d", m_tdata[15:0]);
                errors++;
            end else begin
                e = expected_stats.pop_front();
                if (m_tdata[15:0] !== e.index) begin
                    $error("pixel_index exp %0d got %0d", e.index, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[39:16] !== e.mean) begin
                    $error("mean_q8 exp %0d got %0d", e.mean, m_tdata[39:16]);
                    errors++;
                end
                if (m_tdata[77:40] !== e.variance) begin
                    $error("variance_q8 exp %0d got %0d", e.variance, m_tdata[77:40]);
                    errors++;
                end
                if (m_tuser !== e.overflow) begin
                    $error("frames_overflow exp %0d got %0d", e.overflow, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_pixel exp %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic wait_drained(input int settle);
        while (pending_pixels.size() > 0 || s_tvalid || expected_stats.size() > 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_frame_size(input logic [16:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        frame_cfg = v;
    endtask

    // Queues random frames, the last one final; mix randomizes the flag of non-last pixels.
    task automatic queue_stack(input int unsigned size, input int unsigned frames,
                               input bit mix);
        pixel_item_t it;
        for (int f = 0; f < frames; f++) begin
            for (int unsigned px = 0; px < size; px++) begin
                it.value = $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                                   : 16'($urandom);
                it.fin = (f == frames - 1);
                if (mix && px + 1 < size) it.fin = 1'($urandom_range(1));
                pending_pixels.push_back(it);
            end
        end
    endtask

    initial begin
        int unsigned sz;
        int unsigned frm;
        int count;
        pixel_item_t it;
        errors = 0;
        results_seen = 0;
        quiet_cycles = 0;
        recv_hold = 0;
        recv_hold_req = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 50;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cur_pos = 0;
        frames_done = 0;
        ovf_flag = 1'b0;
        frame_cfg = 17'd65536;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a single-pixel frame of size zero, then extremes and a mixed final flag.
        write_frame_size(17'd0);
        it.value = 16'hFFFF; it.fin = 1'b0; pending_pixels.push_back(it);
        it.value = 16'h0000; it.fin = 1'b0; pending_pixels.push_back(it);
        it.value = 16'hFFFF; it.fin = 1'b1; pending_pixels.push_back(it);
        it.value = 16'hFFFF; it.fin = 1'b1; pending_pixels.push_back(it);
        wait_drained(200);
        write_frame_size(17'd4);
        it.value = 16'h0001; it.fin = 1'b0; repeat (4) pending_pixels.push_back(it);
        it.value = 16'hFFFF; it.fin = 1'b1; pending_pixels.push_back(it);
        it.fin = 1'b0; pending_pixels.push_back(it);
        it.fin = 1'b1; pending_pixels.push_back(it);
        it.fin = 1'b0; pending_pixels.push_back(it);
        it.fin = 1'b0; repeat (4) pending_pixels.push_back(it);
        // Frame size shrinks between frames: a frame of three final pixels follows.
        wait_drained(200);
        write_frame_size(17'd3);
        it.value = 16'h8000; it.fin = 1'b1; repeat (3) pending_pixels.push_back(it);
        wait_drained(200);
        // A size above the maximum acts as the maximum; only a few pixels of it are sent.
        write_frame_size(17'h1FFFF);
        it.value = 16'h1234; it.fin = 1'b1; repeat (3) pending_pixels.push_back(it);
        wait_drained(200);
        write_frame_size(17'd65536);
        it.fin = 1'b0; repeat (2) pending_pixels.push_back(it);
        wait_drained(200);
        // Finish the partial run in a fresh frame size; shrinking keeps every read written.
        write_frame_size(17'd1);
        it.fin = 1'b1; pending_pixels.push_back(it);
        wait_drained(200);

        // Long receiver hold while the sender keeps offering.
        write_frame_size(17'd5);
        queue_stack(5, 3, 1'b0);
        recv_hold_req = 1'b1;
        wait_drained(200);

        count = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 50;
                recv_idle_pct = 19;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (count < 400 * (ph + 1)) begin
                sz = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
                frm = $urandom_range(1, 8);
                write_frame_size(17'(sz));
                queue_stack(sz, frm, $urandom_range(4) == 0);
                count += sz * frm;
                wait_drained(200);
            end
        end

        $display("Covered %0d results over directed cases and random stacks of frames,",
                 results_seen);
        $display("with frame sizes from zero up to the maximum and all idling patterns.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
